### sv/ble_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and codes of the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;

   // request codes
   localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [3:0] OP_POP_FRONT  = 4'd2;
   localparam logic [3:0] OP_POP_BACK   = 4'd3;
   localparam logic [3:0] OP_READ       = 4'd4;
   localparam logic [3:0] OP_WRITE      = 4'd5;
   localparam logic [3:0] OP_SEARCH     = 4'd6;
   localparam logic [3:0] OP_GREATER    = 4'd7;
   localparam logic [3:0] OP_CLEAR      = 4'd8;
   localparam logic [3:0] OP_MEAN       = 4'd9;

   // result status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_BADIDX = 2'd2;
   localparam logic [1:0] STAT_FULL   = 2'd3;

   localparam logic [4:0] POS_NONE = 5'h1F;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD_WAIT,
      S_WALK_ADDR,
      S_WALK_DATA,
      S_DIV_START,
      S_DIV_WAIT,
      S_FINISH
   } state_type;

endpackage

### sv/bounded_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_engine_core
// Double-ended list of signed 32-bit values with indexed access.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one request beat (operation, index, value); rsp_ returns
//   exactly one result beat per request (data, found, position, count,
//   status). Both are valid/ready channels.
//   Path from acceptance to the result being loaded:
//     push, pop, write, clear, bad index: straight from idle
//     read: through the RAM read wait state (S_RD_WAIT)
//     search, first greater: an address step and a data step per element,
//       as the entry RAM has a single registered read port
//     mean: the element walk, then the divider start and wait states,
//       the tail being the bit-per-cycle divider
//   One request is processed at a time; req_ready is high only while idle.
//   The result register holds one finished beat, so the next request may
//   be taken while rsp_ stalls; its result waits until that beat leaves.
//   Synchronous reset empties the list (head and count to zero) and drops
//   any pending result; entry contents are left as they are.
// ----------------------------------------------------------------------------
module bounded_list_engine_core #(
   parameter int DEPTH = ble_pkg::DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_operation,
   input  logic [3:0]         req_index,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_data,
   output logic               rsp_found,
   output logic signed [4:0]  rsp_position,
   output logic [4:0]         rsp_count,
   output logic [1:0]         rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 4) ? CW : 4;
   localparam int SW = ble_pkg::DATA_W + CW;

   ble_pkg::state_type state_ff, state_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      walk_ff, walk_in;
   logic [3:0]         op_ff, op_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [31:0] res_data_ff, res_data_in;
   logic               res_found_ff, res_found_in;
   logic               res_hit_ff, res_hit_in;
   logic [4:0]         res_pos_ff, res_pos_in;
   logic [1:0]         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_data_ff;
   logic               rsp_found_ff;
   logic [4:0]         rsp_pos_ff;
   logic [4:0]         rsp_count_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_load;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_data;
   logic signed [31:0] elem;
   logic               div_start;
   logic               div_done;
   logic signed [SW-1:0] div_quot;
   logic               accept;
   logic               full;
   logic               empty;
   logic               bad_idx;
   logic [AW-1:0]      head_dec;
   logic [AW-1:0]      head_inc;

   // ring slot of a position counted from the front
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] hd, input logic [PW-1:0] pos);
      logic [PW:0] s;
      s = (PW+1)'(hd) + (PW+1)'(pos);
      if (s >= (PW+1)'(DEPTH)) begin
         s = s - (PW+1)'(DEPTH);
      end
      return AW'(s);
   endfunction

   ble_ram #(
      .WIDTH (ble_pkg::DATA_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ble_div #(
      .DW (SW),
      .VW (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == ble_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign elem      = $signed(rd_data);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign bad_idx   = PW'(req_index) >= PW'(count_ff);
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign rsp_load  = (state_ff == ble_pkg::S_FINISH) && (!rsp_valid_ff || rsp_ready);

   // sequencer: next state, list pointers and result fields
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      sum_in        = sum_ff;
      res_data_in   = res_data_ff;
      res_found_in  = res_found_ff;
      res_hit_in    = res_hit_ff;
      res_pos_in    = res_pos_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = slot(head_ff, PW'(req_index));
      wr_data       = req_value;
      rd_addr       = slot(head_ff, PW'(walk_ff));
      div_start     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end

      case (state_ff)
         ble_pkg::S_IDLE: begin
            rd_addr = slot(head_ff, PW'(req_index));
            if (accept) begin
               op_in         = req_operation;
               val_in        = req_value;
               res_data_in   = '0;
               res_found_in  = 1'b0;
               res_hit_in    = 1'b0;
               res_pos_in    = '0;
               res_status_in = ble_pkg::STAT_OK;
               walk_in       = '0;
               sum_in        = '0;
               state_in      = ble_pkg::S_FINISH;
               case (req_operation)
                  ble_pkg::OP_PUSH_FRONT: begin
                     if (full) begin
                        res_status_in = ble_pkg::STAT_FULL;
                     end else begin
                        head_in  = head_dec;
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ble_pkg::OP_PUSH_BACK: begin
                     if (full) begin
                        res_status_in = ble_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot(head_ff, PW'(count_ff));
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ble_pkg::OP_POP_FRONT: begin
                     if (empty) begin
                        res_status_in = ble_pkg::STAT_EMPTY;
                     end else begin
                        head_in  = head_inc;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  ble_pkg::OP_POP_BACK: begin
                     if (empty) begin
                        res_status_in = ble_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  ble_pkg::OP_READ: begin
                     if (bad_idx) begin
                        res_status_in = ble_pkg::STAT_BADIDX;
                     end else begin
                        state_in = ble_pkg::S_RD_WAIT;
                     end
                  end
                  ble_pkg::OP_WRITE: begin
                     if (bad_idx) begin
                        res_status_in = ble_pkg::STAT_BADIDX;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end
                  ble_pkg::OP_SEARCH: begin
                     if (!empty) begin
                        state_in = ble_pkg::S_WALK_ADDR;
                     end
                  end
                  ble_pkg::OP_GREATER: begin
                     res_pos_in = ble_pkg::POS_NONE;
                     if (!empty) begin
                        state_in = ble_pkg::S_WALK_ADDR;
                     end
                  end
                  ble_pkg::OP_CLEAR: begin
                     count_in = '0;
                     head_in  = '0;
                  end
                  ble_pkg::OP_MEAN: begin
                     if (empty) begin
                        res_status_in = ble_pkg::STAT_EMPTY;
                     end else begin
                        state_in = ble_pkg::S_WALK_ADDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ble_pkg::S_RD_WAIT: begin
            res_data_in = elem;
            state_in    = ble_pkg::S_FINISH;
         end
         ble_pkg::S_WALK_ADDR: begin
            state_in = ble_pkg::S_WALK_DATA;
         end
         ble_pkg::S_WALK_DATA: begin
            // fold one element into the running result
            if (elem == val_ff) begin
               res_found_in = 1'b1;
            end
            if (!res_hit_ff && (elem > val_ff)) begin
               res_hit_in = 1'b1;
               res_pos_in = 5'(walk_ff);
            end
            sum_in  = sum_ff + SW'(elem);
            walk_in = walk_ff + CW'(1);
            if (walk_ff + CW'(1) == count_ff) begin
               state_in = (op_ff == ble_pkg::OP_MEAN) ? ble_pkg::S_DIV_START
                                                       : ble_pkg::S_FINISH;
            end else begin
               state_in = ble_pkg::S_WALK_ADDR;
            end
            if (op_ff != ble_pkg::OP_SEARCH) begin
               res_found_in = 1'b0;
            end
            if (op_ff != ble_pkg::OP_GREATER) begin
               res_hit_in = 1'b0;
               res_pos_in = '0;
            end
         end
         ble_pkg::S_DIV_START: begin
            div_start = 1'b1;
            state_in  = ble_pkg::S_DIV_WAIT;
         end
         ble_pkg::S_DIV_WAIT: begin
            if (div_done) begin
               res_data_in = div_quot[31:0];
               state_in    = ble_pkg::S_FINISH;
            end
         end
         ble_pkg::S_FINISH: begin
            if (rsp_load) begin
               state_in = ble_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ble_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ble_pkg::S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      op_ff         <= op_in;
      val_ff        <= val_in;
      sum_ff        <= sum_in;
      res_data_ff   <= res_data_in;
      res_found_ff  <= res_found_in;
      res_hit_ff    <= res_hit_in;
      res_pos_ff    <= res_pos_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_data_ff   <= res_data_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_pos_ff    <= res_pos_ff;
         rsp_count_ff  <= 5'(count_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = $signed(rsp_pos_ff);
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_status_ff;

   // list never holds more than DEPTH entries
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("count above depth");

   // head stays inside the ring
   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= AW'(DEPTH - 1))
      else $error("head outside ring");

   // walk index stays below the count while scanning
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ble_pkg::S_WALK_ADDR || state_ff == ble_pkg::S_WALK_DATA)
      |-> walk_ff < count_ff)
      else $error("walk past end");

   // clear empties the list
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == ble_pkg::OP_CLEAR) |=> (count_ff == '0 && head_ff == '0))
      else $error("clear left entries");

endmodule

### sv/ble_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ble_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/ble_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_div
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module ble_div #(
   parameter int DW = 37,
   parameter int VW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [DW-1:0] dividend,
   input  logic [VW-1:0]        divisor,
   output logic                 done,
   output logic signed [DW-1:0] quotient
);

   localparam int NW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          neg_ff, neg_in;
   logic [DW-1:0] q_ff, q_in;
   logic [VW:0]   r_ff, r_in;
   logic [VW-1:0] d_ff, d_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [VW:0]   shifted;
   logic          ge;

   // one restoring step
   always_comb begin
      shifted = {r_ff[VW-1:0], q_ff[DW-1]};
      ge      = shifted >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[DW-1];
         q_in    = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
         r_in    = '0;
         d_in    = divisor;
         cnt_in  = '0;
      end else if (busy_ff) begin
         r_in   = ge ? shifted - {1'b0, d_ff} : shifted;
         q_in   = {q_ff[DW-2:0], ge};
         cnt_in = cnt_ff + NW'(1);
         if (cnt_ff == NW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

endmodule

### tb/tb_bounded_list_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_list_engine_core
// Self-checking bench for the bounded list engine.
// ----------------------------------------------------------------------------
// A directed table covers the empty, full and bad-index cases, every
// operation and the value extremes. It is followed by random requests,
// mostly with valid indexes and fill levels that sweep the whole depth.
// A behavioral model of the list predicts each result beat. Both channels
// idle at random between beats.
// ----------------------------------------------------------------------------
module tb_bounded_list_engine_core;

   localparam int LIST_DEPTH = 16;
   localparam int N_RANDOM   = 1100;

   typedef struct {
      logic [3:0]         op;
      logic [3:0]         idx;
      logic signed [31:0] val;
   } req_type;

   typedef struct {
      logic signed [31:0] data;
      logic               found;
      logic signed [4:0]  position;
      logic [4:0]         count;
      logic [1:0]         status;
   } rsp_type;

   // directed row: request plus an optional typed-in expectation
   typedef struct {
      req_type req;
      bit      has_exp;
      rsp_type exp;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_operation = '0;
   logic [3:0]         req_index = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_data;
   logic               rsp_found;
   logic signed [4:0]  rsp_position;
   logic [4:0]         rsp_count;
   logic [1:0]         rsp_status;

   // model state of the list
   logic signed [31:0] list_mem [LIST_DEPTH];
   int unsigned        list_head = 0;
   int unsigned        list_count = 0;

   rsp_type pending_rsp [$];
   int      n_errors = 0;
   bit      stim_done = 1'b0;

   always #6 clock = ~clock;

   bounded_list_engine_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status)
   );

   function automatic int unsigned ring_slot(int unsigned pos);
      return (list_head + pos) % LIST_DEPTH;
   endfunction

   // apply one request to the list model and return its result
   function automatic rsp_type list_apply(req_type r);
      rsp_type     o;
      longint      sum;
      int unsigned i;
      o.data = '0;
      o.found = 1'b0;
      o.position = '0;
      o.status = ble_pkg::STAT_OK;
      sum = 0;
      case (r.op)
         ble_pkg::OP_PUSH_FRONT: begin
            if (list_count >= LIST_DEPTH) o.status = ble_pkg::STAT_FULL;
            else begin
               list_head = (list_head + LIST_DEPTH - 1) % LIST_DEPTH;
               list_mem[list_head] = r.val;
               list_count++;
            end
         end
         ble_pkg::OP_PUSH_BACK: begin
            if (list_count >= LIST_DEPTH) o.status = ble_pkg::STAT_FULL;
            else begin
               list_mem[ring_slot(list_count)] = r.val;
               list_count++;
            end
         end
         ble_pkg::OP_POP_FRONT: begin
            if (list_count == 0) o.status = ble_pkg::STAT_EMPTY;
            else begin
               list_head = (list_head + 1) % LIST_DEPTH;
               list_count--;
            end
         end
         ble_pkg::OP_POP_BACK: begin
            if (list_count == 0) o.status = ble_pkg::STAT_EMPTY;
            else list_count--;
         end
         ble_pkg::OP_READ: begin
            if (r.idx >= list_count) o.status = ble_pkg::STAT_BADIDX;
            else o.data = list_mem[ring_slot(r.idx)];
         end
         ble_pkg::OP_WRITE: begin
            if (r.idx >= list_count) o.status = ble_pkg::STAT_BADIDX;
            else list_mem[ring_slot(r.idx)] = r.val;
         end
         ble_pkg::OP_SEARCH: begin
            for (i = 0; i < list_count; i++)
               if (list_mem[ring_slot(i)] == r.val) begin
                  o.found = 1'b1;
                  break;
               end
         end
         ble_pkg::OP_GREATER: begin
            o.position = ble_pkg::POS_NONE;
            for (i = 0; i < list_count; i++)
               if (list_mem[ring_slot(i)] > r.val) begin
                  o.position = i[4:0];
                  break;
               end
         end
         ble_pkg::OP_CLEAR: begin
            list_count = 0;
            list_head = 0;
         end
         ble_pkg::OP_MEAN: begin
            if (list_count == 0) o.status = ble_pkg::STAT_EMPTY;
            else begin
               for (i = 0; i < list_count; i++)
                  sum += longint'(list_mem[ring_slot(i)]);
               sum = sum / longint'(list_count);
               o.data = sum[31:0];
            end
         end
         default: ;
      endcase
      o.count = list_count[4:0];
      return o;
   endfunction

   // field-by-field compare of two result beats
   function automatic bit rsp_differs(rsp_type a, rsp_type b);
      return (a.data !== b.data) || (a.found !== b.found) ||
             (a.position !== b.position) || (a.count !== b.count) ||
             (a.status !== b.status);
   endfunction

   function automatic rsp_type mk_rsp(logic signed [31:0] d, logic f, logic signed [4:0] p,
                                      logic [4:0] c, logic [1:0] s);
      rsp_type o;
      o.data = d;
      o.found = f;
      o.position = p;
      o.count = c;
      o.status = s;
      return o;
   endfunction

   function automatic row_type mk_row(logic [3:0] op, logic [3:0] idx,
                                      logic signed [31:0] val, bit has_exp, rsp_type exp);
      row_type w;
      w.req.op = op;
      w.req.idx = idx;
      w.req.val = val;
      w.has_exp = has_exp;
      w.exp = exp;
      return w;
   endfunction

   // drive one request beat after a random gap; queue its expectation
   task automatic send_req(req_type r, bit has_exp, rsp_type exp);
      rsp_type pred;
      int      gap;
      gap = $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_index <= r.idx;
      req_value <= r.val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pred = list_apply(r);
      if (has_exp && rsp_differs(pred, exp)) begin
         $error("table row disagrees with model: op %0d", r.op);
         n_errors++;
      end
      pending_rsp.push_back(has_exp ? exp : pred);
      @(negedge clock);
   endtask

   // random request: mostly meaningful ops and in-range indexes
   function automatic req_type rand_req();
      req_type r;
      int      k;
      k = $urandom_range(0, 99);
      if (k < 3) r.op = 4'($urandom_range(10, 15));
      else if (k < 5) r.op = ble_pkg::OP_CLEAR;
      else if (list_count < 4 && k < 50) r.op = 4'($urandom_range(0, 1));
      else if (list_count > 12 && k < 40) r.op = 4'($urandom_range(2, 3));
      else r.op = 4'($urandom_range(0, 9));
      if (r.op == ble_pkg::OP_CLEAR && $urandom_range(0, 3) != 0) r.op = ble_pkg::OP_MEAN;
      if (list_count > 0 && $urandom_range(0, 4) != 0)
         r.idx = 4'($urandom_range(0, list_count - 1));
      else r.idx = 4'($urandom);
      case ($urandom_range(0, 5))
         0: r.val = $signed($urandom);
         1: r.val = $signed(32'($urandom_range(0, 7)) - 32'sd3);
         2: r.val = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
         3: r.val = (list_count > 0) ? list_mem[ring_slot($urandom_range(0, list_count - 1))]
                                     : $signed($urandom);
         default: r.val = $signed($urandom_range(0, 2000)) - 32'sd1000;
      endcase
      return r;
   endfunction

   // stimulus
   initial begin
      row_type rows [$];
      rsp_type none;
      req_type r;
      none = mk_rsp('0, 1'b0, '0, '0, ble_pkg::STAT_OK);
      rows.push_back(mk_row(ble_pkg::OP_POP_FRONT, 0, 0, 1,
                            mk_rsp(0, 0, 0, 0, ble_pkg::STAT_EMPTY)));
      rows.push_back(mk_row(ble_pkg::OP_POP_BACK, 0, 0, 1,
                            mk_rsp(0, 0, 0, 0, ble_pkg::STAT_EMPTY)));
      rows.push_back(mk_row(ble_pkg::OP_READ, 0, 0, 1,
                            mk_rsp(0, 0, 0, 0, ble_pkg::STAT_BADIDX)));
      rows.push_back(mk_row(ble_pkg::OP_WRITE, 15, -1, 1,
                            mk_rsp(0, 0, 0, 0, ble_pkg::STAT_BADIDX)));
      rows.push_back(mk_row(ble_pkg::OP_MEAN, 0, 0, 1,
                            mk_rsp(0, 0, 0, 0, ble_pkg::STAT_EMPTY)));
      rows.push_back(mk_row(ble_pkg::OP_SEARCH, 0, 0, 1,
                            mk_rsp(0, 0, 0, 0, ble_pkg::STAT_OK)));
      rows.push_back(mk_row(ble_pkg::OP_GREATER, 0, 0, 1,
                            mk_rsp(0, 0, ble_pkg::POS_NONE, 0, ble_pkg::STAT_OK)));
      rows.push_back(mk_row(4'd15, 15, -1, 1, mk_rsp(0, 0, 0, 0, ble_pkg::STAT_OK)));
      rows.push_back(mk_row(ble_pkg::OP_PUSH_BACK, 0, 32'sh7FFFFFFF, 1,
                            mk_rsp(0, 0, 0, 1, ble_pkg::STAT_OK)));
      rows.push_back(mk_row(ble_pkg::OP_PUSH_FRONT, 0, 32'sh80000000, 1,
                            mk_rsp(0, 0, 0, 2, ble_pkg::STAT_OK)));
      rows.push_back(mk_row(ble_pkg::OP_READ, 0, 0, 1,
                            mk_rsp(32'sh80000000, 0, 0, 2, ble_pkg::STAT_OK)));
      rows.push_back(mk_row(ble_pkg::OP_READ, 1, 0, 1,
                            mk_rsp(32'sh7FFFFFFF, 0, 0, 2, ble_pkg::STAT_OK)));
      rows.push_back(mk_row(ble_pkg::OP_MEAN, 0, 0, 0, none));
      rows.push_back(mk_row(ble_pkg::OP_GREATER, 0, -5, 0, none));
      rows.push_back(mk_row(ble_pkg::OP_SEARCH, 0, 32'sh7FFFFFFF, 0, none));
      rows.push_back(mk_row(ble_pkg::OP_WRITE, 1, 32'sh55AA33CC, 0, none));
      for (int i = 0; i < 14; i++)
         rows.push_back(mk_row(i[0] ? ble_pkg::OP_PUSH_FRONT : ble_pkg::OP_PUSH_BACK, 0,
                               32'sh7FFFFFF0 + i, 0, none));
      rows.push_back(mk_row(ble_pkg::OP_PUSH_BACK, 0, 1, 1,
                            mk_rsp(0, 0, 0, 16, ble_pkg::STAT_FULL)));
      rows.push_back(mk_row(ble_pkg::OP_MEAN, 0, 0, 0, none));
      rows.push_back(mk_row(ble_pkg::OP_READ, 15, 0, 0, none));
      rows.push_back(mk_row(ble_pkg::OP_GREATER, 0, 32'sh7FFFFFFE, 0, none));
      rows.push_back(mk_row(ble_pkg::OP_CLEAR, 0, 0, 1,
                            mk_rsp(0, 0, 0, 0, ble_pkg::STAT_OK)));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_req(rows[i].req, rows[i].has_exp, rows[i].exp);
      for (int n = 0; n < N_RANDOM; n++) begin
         r = rand_req();
         send_req(r, 0, none);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side: random stalls, compare against oldest expectation
   initial begin
      rsp_type exp;
      int      stall;
      forever begin
         @(negedge clock);
         if (reset) continue;
         stall = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) stall = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (pending_rsp.size() == 0) begin
            $error("result beat with no request outstanding");
            n_errors++;
         end else begin
            exp = pending_rsp.pop_front();
            if (rsp_data !== exp.data) begin
               $error("data: expected %0d actual %0d", exp.data, rsp_data);
               n_errors++;
            end
            if (rsp_found !== exp.found) begin
               $error("found: expected %0d actual %0d", exp.found, rsp_found);
               n_errors++;
            end
            if (rsp_position !== exp.position) begin
               $error("position: expected %0d actual %0d", exp.position, rsp_position);
               n_errors++;
            end
            if (rsp_count !== exp.count) begin
               $error("count: expected %0d actual %0d", exp.count, rsp_count);
               n_errors++;
            end
            if (rsp_status !== exp.status) begin
               $error("status: expected %0d actual %0d", exp.status, rsp_status);
               n_errors++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (n_errors == 0 && pending_rsp.size() == 0)
         $display("bounded_list_engine_core verification clean");
      else
         $display("bounded_list_engine_core verification failed");
      $finish;
   end

   // watchdog: sized to cover ~1200 beats with gaps, mean requests and stalls
   initial begin
      #5_000_000;
      $display("bounded_list_engine_core verification failed");
      $finish;
   end

endmodule

### files.f
sv/ble_pkg.sv
sv/ble_ram.sv
sv/ble_div.sv
sv/bounded_list_engine_core.sv
tb/tb_bounded_list_engine_core.sv
